[hdl/crit_pkg.sv]
// shared types and constants for the copy range invalidation table
// no dependencies; imported by crit_ctrl, crit_dpath and the top level
package crit_pkg;

  localparam int ADDR_W              = 32;
  localparam int LEN_W               = 32;
  localparam int COUNT_W             = 5;
  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int S_TDATA_W           = 64;
  localparam int M_TDATA_W           = 40;
  localparam int WORD_W              = ADDR_W + LEN_W;

  localparam logic CMD_REMEMBER   = 1'b0;
  localparam logic CMD_INVALIDATE = 1'b1;
  localparam logic KIND_RETIRED   = 1'b0;
  localparam logic KIND_DONE      = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic emit;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic size_zero;
    logic is_inval;
    logic scan_done;
    logic list_empty;
    logic out_free;
  } ctrl_stat_t;

endpackage

[hdl/copy_range_invalidation_table.sv]
// top level of the copy range invalidation table
// depends on crit_pkg, crit_ctrl and crit_dpath
//
// Keeps up to TABLE_DEPTH tracked ranges (start address, nonzero length),
// one per start address. An input beat with tuser = 0 remembers a range: a
// held start gets its length replaced, otherwise the lowest free entry takes
// it, and with no free entry the reply carries table_full and nothing is
// stored. A beat with tuser = 1 invalidates every range overlapping
// [addr, addr+size), ends taken at 33 bits so they never wrap; each removed
// start address comes out as a kind 0 beat in ascending order, then a done
// beat (kind 1, tlast) with the count. Remember always answers with a single
// done beat. A size of zero changes nothing and answers with an empty done
// beat. One item is handled at a time: the entries are scanned through the
// single read port of the range memory, one per cycle, then an invalidate
// emits its removed starts before the done beat, and any output stall holds
// the emit and done beats. A new item is taken as soon as the done beat sits
// in the output register.
// No clearing pass after reset: valid bits are flip-flops cleared at once.
module copy_range_invalidation_table #(
  parameter int TABLE_DEPTH = crit_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [crit_pkg::S_TDATA_W-1:0] s_tdata,   // addr[31:0], size[63:32]
  input  logic                           s_tuser,   // command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [crit_pkg::M_TDATA_W-1:0] m_tdata,   // retired_addr[31:0], retired_count[36:32],
                                                    // table_full[37], zero pad[39:38]
  output logic                           m_tuser,   // kind
  output logic                           m_tlast    // last
);
  import crit_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencer: accept, scan, emit retired starts, done beat
  crit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // range memory, valid bits, sorted list and output register
  crit_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

[hdl/crit_ctrl.sv]
// sequencer for the copy range invalidation table
// depends on crit_pkg; drives crit_dpath through ctrl_cmd_t, watches ctrl_stat_t
module crit_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  crit_pkg::ctrl_stat_t stat,
  output crit_pkg::ctrl_cmd_t  cmd
);
  import crit_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.size_zero) begin
          state_next = ST_DONE;
        end else if (stat.scan_done) begin
          state_next = stat.is_inval ? ST_EMIT : ST_DONE;
        end
      end
      ST_EMIT: begin
        if (stat.list_empty) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_SCAN: begin
        cmd.scan = !stat.size_zero && !stat.scan_done;
      end
      ST_EMIT: begin
        cmd.emit = !stat.list_empty && stat.out_free;
      end
      ST_DONE: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

[hdl/crit_dpath.sv]
// range memory, valid bits, sorted retire list and output register
// depends on crit_pkg; sequenced by crit_ctrl
module crit_dpath #(
  parameter int TABLE_DEPTH = crit_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [crit_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [crit_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast,
  input  crit_pkg::ctrl_cmd_t            cmd,
  output crit_pkg::ctrl_stat_t           stat
);
  import crit_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int PAD_W = M_TDATA_W - ADDR_W - COUNT_W - 1;

  // latched item
  logic              item_cmd;
  logic [ADDR_W-1:0] item_addr;
  logic [LEN_W-1:0]  item_size;
  logic [ADDR_W:0]   item_dend;
  logic              size_zero;

  // scan pipeline
  logic [CNT_W-1:0]  iss_idx;
  logic              issue;
  logic              chk_vld;
  logic [IDX_W-1:0]  chk_idx;
  logic [WORD_W-1:0] rd_word;
  logic [ADDR_W-1:0] rd_start;
  logic [LEN_W-1:0]  rd_len;
  logic [ADDR_W:0]   rd_end;
  logic              overlap;
  logic              inv_hit;

  // table
  logic [WORD_W-1:0]      mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic                   match_found;
  logic [IDX_W-1:0]       match_idx;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic                   commit;
  logic [IDX_W-1:0]       wr_idx;
  logic                   full_flag;

  // sorted retire list
  logic [ADDR_W-1:0]      list     [TABLE_DEPTH];
  logic [ADDR_W-1:0]      list_ins [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gt;
  logic [CNT_W-1:0]       n_total;
  logic [CNT_W-1:0]       n_left;

  // output register
  logic              out_free;
  logic [ADDR_W-1:0] out_addr;
  logic [COUNT_W-1:0] out_count;
  logic              out_full;

  assign size_zero = (item_size == '0);
  assign issue     = cmd.scan && (iss_idx != CNT_W'(TABLE_DEPTH));
  assign rd_start  = rd_word[ADDR_W-1:0];
  assign rd_len    = rd_word[WORD_W-1:ADDR_W];
  assign rd_end    = {1'b0, rd_start} + {1'b0, rd_len};
  assign overlap   = (item_dend > {1'b0, rd_start}) && ({1'b0, item_addr} < rd_end);
  assign inv_hit   = chk_vld && (item_cmd == CMD_INVALIDATE) && entry_valid[chk_idx] && overlap;
  assign commit    = cmd.finish && (item_cmd == CMD_REMEMBER) && !size_zero
                     && (match_found || free_found);
  assign wr_idx    = match_found ? match_idx : free_idx;
  assign full_flag = (item_cmd == CMD_REMEMBER) && !size_zero && !match_found && !free_found;
  assign out_free  = !m_tvalid || m_tready;

  assign stat.size_zero  = size_zero;
  assign stat.is_inval   = (item_cmd == CMD_INVALIDATE);
  assign stat.scan_done  = (iss_idx == CNT_W'(TABLE_DEPTH)) && !chk_vld;
  assign stat.list_empty = (n_left == '0);
  assign stat.out_free   = out_free;

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd  <= s_tuser;
      item_addr <= s_tdata[ADDR_W-1:0];
      item_size <= s_tdata[ADDR_W+LEN_W-1:ADDR_W];
      item_dend <= {1'b0, s_tdata[ADDR_W-1:0]} + {1'b0, s_tdata[ADDR_W+LEN_W-1:ADDR_W]};
    end
  end

  // range memory: one read port for the scan, one write port for remember
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_word <= mem[iss_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      mem[wr_idx] <= {item_size, item_addr};
    end
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
      iss_idx <= '0;
    end else if (cmd.load) begin
      chk_vld <= 1'b0;
      iss_idx <= '0;
    end else begin
      chk_vld <= issue;
      if (issue) begin
        iss_idx <= iss_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      chk_idx <= iss_idx[IDX_W-1:0];
    end
  end

  // remember lookup: held start and lowest free entry
  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmd.load) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (chk_vld && (item_cmd == CMD_REMEMBER)) begin
      if (entry_valid[chk_idx] && (rd_start == item_addr)) begin
        match_found <= 1'b1;
        match_idx   <= chk_idx;
      end
      if (!entry_valid[chk_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (inv_hit) begin
      entry_valid[chk_idx] <= 1'b0;
    end else if (commit) begin
      entry_valid[wr_idx] <= 1'b1;
    end
  end

  // insertion into the ascending list, every slot decides on its own
  always_comb begin
    logic              prev_gt;
    logic [ADDR_W-1:0] prev_val;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      gt[j] = (CNT_W'(j) < n_total) && (list[j] > rd_start);
    end
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (j == 0) begin
        prev_gt  = 1'b0;
        prev_val = rd_start;
      end else begin
        prev_gt  = gt[j-1];
        prev_val = list[j-1];
      end
      if (CNT_W'(j) < n_total) begin
        list_ins[j] = gt[j] ? (prev_gt ? prev_val : rd_start) : list[j];
      end else if (CNT_W'(j) == n_total) begin
        list_ins[j] = prev_gt ? prev_val : rd_start;
      end else begin
        list_ins[j] = list[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (inv_hit) begin
      list <= list_ins;
    end else if (cmd.emit) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        list[j] <= list[(j + 1 < TABLE_DEPTH) ? j + 1 : j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_total <= '0;
      n_left  <= '0;
    end else if (cmd.load) begin
      n_total <= '0;
      n_left  <= '0;
    end else if (inv_hit) begin
      n_total <= n_total + CNT_W'(1);
      n_left  <= n_left + CNT_W'(1);
    end else if (cmd.emit) begin
      n_left <= n_left - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit || cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser   <= KIND_RETIRED;
      m_tlast   <= 1'b0;
      out_addr  <= list[0];
      out_count <= '0;
      out_full  <= 1'b0;
    end else if (cmd.finish) begin
      m_tuser   <= KIND_DONE;
      m_tlast   <= 1'b1;
      out_addr  <= '0;
      out_count <= COUNT_W'(n_total);
      out_full  <= full_flag;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_full, out_count, out_addr};

endmodule

[verif/copy_range_invalidation_table_test.sv]
// self-checking bench for the copy range invalidation table: streams remember
// and invalidate beats, predicts the retired starts and done beats in step
// depends on crit_pkg and copy_range_invalidation_table
module copy_range_invalidation_table_test;
  import crit_pkg::*;

  localparam int DEPTH      = DEFAULT_TABLE_DEPTH;
  localparam int HALF_CYCLE = 4;

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  typedef struct {
    logic        cmd;
    logic [31:0] addr;
    logic [31:0] size;
  } command_t;

  typedef struct {
    logic        kind;
    logic [31:0] addr;
    logic [4:0]  count;
    logic        full;
    logic        last;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  // bench copy of the tracked ranges
  logic        held_valid [DEPTH];
  logic [31:0] held_start [DEPTH];
  logic [31:0] held_len   [DEPTH];

  command_t pending_cmds[$];
  reply_t   expected_replies[$];
  pace_t    pace = PACE_FULL;
  int       mismatches = 0;
  int       queued_cmds = 0;
  int       hold_left = 0;
  logic     hold_kick = 1'b0;

  copy_range_invalidation_table #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #HALF_CYCLE clk = 1'b1;
    #HALF_CYCLE clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) held_valid[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic reply_t make_reply(logic kind, logic [31:0] addr, logic [4:0] count,
                                        logic full, logic last);
    reply_t r;
    r.kind  = kind;
    r.addr  = addr;
    r.count = count;
    r.full  = full;
    r.last  = last;
    return r;
  endfunction

  // appends one reply to the tail of the expected queue
  function automatic void add_reply(reply_t r);
    expected_replies = {expected_replies, r};
  endfunction

  // updates the range table for one accepted command and queues its replies
  task automatic track_command(logic cmd, logic [31:0] addr, logic [31:0] size);
    logic [32:0] span_end;
    logic [32:0] held_end;
    logic        hit;
    logic        taken [DEPTH];
    int          free_slot;
    int          removed;
    int          pick;
    if (size == 0) begin
      // zero size: nothing changes, empty done beat
      add_reply(make_reply(KIND_DONE, '0, '0, 1'b0, 1'b1));
    end else if (cmd == CMD_REMEMBER) begin
      hit = 1'b0;
      free_slot = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (!hit) begin
          if (held_valid[i] && held_start[i] == addr) begin
            // held start: length replaced, even on a full table
            held_len[i] = size;
            hit = 1'b1;
          end else if (!held_valid[i] && free_slot < 0) begin
            free_slot = i;
          end
        end
      end
      if (!hit && free_slot >= 0) begin
        held_valid[free_slot] = 1'b1;
        held_start[free_slot] = addr;
        held_len[free_slot]   = size;
      end
      add_reply(make_reply(KIND_DONE, '0, '0, !hit && free_slot < 0, 1'b1));
    end else begin
      // half-open overlap test with 33-bit ends
      span_end = {1'b0, addr} + {1'b0, size};
      removed = 0;
      for (int i = 0; i < DEPTH; i++) begin
        taken[i] = 1'b0;
        if (held_valid[i]) begin
          held_end = {1'b0, held_start[i]} + {1'b0, held_len[i]};
          if (!(span_end <= {1'b0, held_start[i]} || {1'b0, addr} >= held_end)) begin
            taken[i] = 1'b1;
            held_valid[i] = 1'b0;
            removed++;
          end
        end
      end
      // starts are unique, so picking the smallest each time gives ascending order
      for (int k = 0; k < removed; k++) begin
        pick = -1;
        for (int i = 0; i < DEPTH; i++)
          if (taken[i] && (pick < 0 || held_start[i] < held_start[pick])) pick = i;
        taken[pick] = 1'b0;
        add_reply(make_reply(KIND_RETIRED, held_start[pick], '0, 1'b0, 1'b0));
      end
      add_reply(make_reply(KIND_DONE, '0, removed[4:0], 1'b0, 1'b1));
    end
  endtask

  function automatic logic sender_rests();
    case (pace)
      PACE_SENDER_IDLE: return $urandom_range(99) < 72;
      PACE_BOTH:        return $urandom_range(99) < 10;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (pace)
      PACE_RECEIVER_STALL: return $urandom_range(99) < 72;
      PACE_BOTH:           return $urandom_range(99) < 10;
      default:             return 1'b0;
    endcase
  endfunction

  // driver: predicts on every accepted beat, then offers the next pending one
  always @(posedge clk) begin
    command_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) track_command(s_tuser, s_tdata[31:0], s_tdata[63:32]);
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && !sender_rests()) begin
          c = pending_cmds.pop_front();
          s_tdata  <= {c.size, c.addr};
          s_tuser  <= c.cmd;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here so the table backs up into the input
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_kick) hold_left <= 400;
  end

  // monitor: compares each output beat with the oldest expected reply
  always @(posedge clk) begin
    reply_t r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected beat: kind %0d addr %h", m_tuser, m_tdata[31:0]);
          mismatches++;
        end else begin
          r = expected_replies.pop_front();
          if (m_tuser !== r.kind) begin
            $error("kind: expected %0d, got %0d", r.kind, m_tuser);
            mismatches++;
          end
          if (m_tdata[31:0] !== r.addr) begin
            $error("retired_addr: expected %h, got %h", r.addr, m_tdata[31:0]);
            mismatches++;
          end
          if (m_tdata[36:32] !== r.count) begin
            $error("retired_count: expected %0d, got %0d", r.count, m_tdata[36:32]);
            mismatches++;
          end
          if (m_tdata[37] !== r.full) begin
            $error("table_full: expected %0d, got %0d", r.full, m_tdata[37]);
            mismatches++;
          end
          if (m_tlast !== r.last) begin
            $error("last: expected %0d, got %0d", r.last, m_tlast);
            mismatches++;
          end
        end
      end
      m_tready <= (hold_left == 0) && !receiver_stalls();
    end
  end

  task automatic queue_command(logic cmd, logic [31:0] addr, logic [31:0] size);
    command_t c;
    c.cmd  = cmd;
    c.addr = addr;
    c.size = size;
    pending_cmds = {pending_cmds, c};
    queued_cmds++;
  endtask

  // a burst of ranges around one base, then spans that hit some of them
  task automatic queue_region_burst();
    logic [31:0] base;
    logic [31:0] starts [8];
    logic [31:0] len;
    int          ranges;
    int          spans;
    if ($urandom_range(4) == 0) base = 32'hFFFF_FC00 + ($urandom_range(63) << 4);
    else base = $urandom() & 32'hFFFF_F000;
    ranges = $urandom_range(1, 8);
    for (int i = 0; i < ranges; i++) begin
      if (i > 0 && $urandom_range(6) == 0) starts[i] = starts[i-1];  // length replace
      else starts[i] = base + ($urandom_range(63) << 4);
      len = $urandom_range(1, 600);
      if ($urandom_range(15) == 0) len = 0;
      queue_command(CMD_REMEMBER, starts[i], len);
    end
    spans = $urandom_range(1, 2);
    for (int i = 0; i < spans; i++) begin
      case ($urandom_range(3))
        0: queue_command(CMD_INVALIDATE, starts[$urandom_range(ranges - 1)], 1);
        1: queue_command(CMD_INVALIDATE, base, 32'h0000_0800);
        default: queue_command(CMD_INVALIDATE, base + $urandom_range(32'h400),
                               $urandom_range(1, 32'h200));
      endcase
    end
    // noise across the whole field range
    if ($urandom_range(3) == 0) queue_command(1'($urandom_range(1)), $urandom(), $urandom());
    if ($urandom_range(3) == 0) queue_command(CMD_INVALIDATE, $urandom(), $urandom_range(32'h2000));
    // now and then clear the table so it does not stay full
    if ($urandom_range(7) == 0) begin
      queue_command(CMD_INVALIDATE, 32'h0, 32'hFFFF_FFFF);
      queue_command(CMD_INVALIDATE, 32'hFFFF_FFFF, 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || s_tvalid || expected_replies.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int target;
    @(negedge rst);
    @(negedge clk);

    // directed: zero size on both commands
    queue_command(CMD_REMEMBER, 32'hFFFF_FFFF, 0);
    queue_command(CMD_INVALIDATE, 32'h0, 0);
    // fill every entry, extremes first, rest at falling addresses
    queue_command(CMD_REMEMBER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_command(CMD_REMEMBER, 32'h0000_0000, 32'hFFFF_FFFF);
    for (int i = 2; i < DEPTH; i++)
      queue_command(CMD_REMEMBER, 32'h8000_0000 - i * 32'h100, 32'h40);
    // full table: a new start is refused, a held start is replaced
    queue_command(CMD_REMEMBER, 32'h1234_5678, 32'h10);
    queue_command(CMD_REMEMBER, 32'h8000_0000 - 32'h200, 32'h80);
    // top address only: the full-length range at zero ends just below it
    queue_command(CMD_INVALIDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // everything else in one go
    queue_command(CMD_INVALIDATE, 32'h0, 32'hFFFF_FFFF);
    wait_drained();

    // random bursts under each pacing
    for (int p = 0; p < 4; p++) begin
      pace = pace_t'(p);
      target = queued_cmds + 30;
      while (queued_cmds < target) queue_region_burst();
      wait_drained();
    end

    // back-pressure: receiver holds off while the sender keeps offering
    pace = PACE_FULL;
    target = queued_cmds + 12;
    while (queued_cmds < target) queue_region_burst();
    hold_kick = 1'b1;
    @(negedge clk);
    hold_kick = 1'b0;
    wait_drained();

    repeat (DEPTH + 40) @(negedge clk);
    if (mismatches == 0) $display("copy_range_invalidation_table_test OK");
    else $display("copy_range_invalidation_table_test NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("copy_range_invalidation_table_test NOT OK");
    $finish;
  end

endmodule
